// ----- rtl/tccc_pkg.sv -----
// Shared types and constants for the text console cursor controller.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package tccc_pkg;

  // Build-time limits of the console
  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 128;
  localparam int TAB_STOP    = 8;    // must be a power of two

  // Saturation points for the column and row registers
  localparam int COL_CAP = (MAX_COLUMNS < 512) ? MAX_COLUMNS : 512;
  localparam int ROW_CAP = (MAX_ROWS < 128) ? MAX_ROWS : 128;

  // Field widths
  localparam int COLS_W  = 9;   // columns register
  localparam int ROWS_W  = 8;   // text_rows register
  localparam int CURC_W  = 9;   // cursor column
  localparam int CURR_W  = 7;   // cursor row
  localparam int CELLC_W = 8;   // cell_column
  localparam int CELLR_W = 7;   // cell_row
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 88;  // 87 payload bits padded to whole bytes

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR  = 3'd4;

  // Register reset values
  localparam logic [COLS_W-1:0]  COLUMNS_RST   = 9'd128;
  localparam logic [ROWS_W-1:0]  TEXT_ROWS_RST = 8'd48;
  localparam logic [COLOR_W-1:0] FG_COLOR_RST  = 32'hFFEE_EEEE;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST  = 32'hFF00_0000;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'd126;

  // Request kinds on the input tuser
  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_DRAW    = 2'd0,
    CMD_SCROLL  = 2'd1,
    CMD_PRESENT = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  // Configuration registers as seen by front and back
  typedef struct packed {
    logic [COLS_W-1:0]  columns;
    logic [ROWS_W-1:0]  text_rows;
    logic               enable;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } cfg_t;

  // One queued job: one or two commands caused by a single item
  typedef struct packed {
    logic               two;      // a second command follows the first
    cmd_t               cmd0;
    cmd_t               cmd1;
    logic [CELLC_W-1:0] col;
    logic [CELLR_W-1:0] row;
    logic [CHAR_W-1:0]  glyph;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/tccc_queue.sv -----
// Small register FIFO that decouples the front from the back.
// Depends on tccc_pkg for the entry type and depth.
`default_nettype none
module tccc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tccc_pkg::entry_t wr_data,
  output logic                 full,
  input  wire logic            pop,
  output tccc_pkg::entry_t     rd_data,
  output logic                 not_empty
);
  import tccc_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule
`default_nettype wire

// ----- rtl/tccc_front.sv -----
// Front end: accepts items, moves the cursor and queues the commands.
// Depends on tccc_pkg; feeds tccc_queue.
`default_nettype none
module tccc_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tccc_pkg::cfg_t                cfg,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [tccc_pkg::CHAR_W-1:0]   s_axis_tdata,  // [7:0] char_code
  input  wire logic                          s_axis_tuser,  // [0] req_type
  input  wire logic                          q_full,
  output logic                               q_push,
  output tccc_pkg::entry_t                   q_entry
);
  import tccc_pkg::*;

  logic [CURC_W-1:0]  cursor_column;
  logic [CURR_W-1:0]  cursor_row;
  logic [CURC_W-1:0]  cursor_column_next;
  logic [CURR_W-1:0]  cursor_row_next;

  logic [CURC_W:0]    eff_cols;
  logic [ROWS_W-1:0]  eff_rows;
  logic [CURR_W:0]    row_inc;
  logic               nl_scroll;
  logic [CURR_W-1:0]  nl_row;
  logic [CURC_W:0]    tab_col;
  logic [CURC_W:0]    inc_col;
  logic [CURC_W-1:0]  dec_col;
  logic               accept;
  logic               emit;
  logic [CHAR_W-1:0]  ch;

  assign s_axis_tready = !q_full;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign ch     = s_axis_tdata;

  // Saturate the geometry registers
  always_comb begin
    if (cfg.columns == '0) begin
      eff_cols = (CURC_W+1)'(1);
    end else if ({1'b0, cfg.columns} > (CURC_W+1)'(COL_CAP)) begin
      eff_cols = (CURC_W+1)'(COL_CAP);
    end else begin
      eff_cols = {1'b0, cfg.columns};
    end
    if (cfg.text_rows == '0) begin
      eff_rows = ROWS_W'(1);
    end else if (cfg.text_rows > ROWS_W'(ROW_CAP)) begin
      eff_rows = ROWS_W'(ROW_CAP);
    end else begin
      eff_rows = cfg.text_rows;
    end
  end

  // Newline: advance the row, hold at the bottom and scroll
  assign row_inc   = {1'b0, cursor_row} + 1'b1;
  assign nl_scroll = (row_inc >= eff_rows);
  assign nl_row    = nl_scroll ? CURR_W'(eff_rows - 1'b1) : row_inc[CURR_W-1:0];

  // Next tab stop: clear the low bits, add one stop
  assign tab_col = {1'b0, cursor_column & ~CURC_W'(TAB_STOP - 1)} + (CURC_W+1)'(TAB_STOP);
  assign inc_col = {1'b0, cursor_column} + 1'b1;
  assign dec_col = cursor_column - 1'b1;

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    emit               = 1'b0;
    q_entry.two        = 1'b0;
    q_entry.cmd0       = CMD_PRESENT;
    q_entry.cmd1       = CMD_PRESENT;
    q_entry.col        = cursor_column[CELLC_W-1:0];
    q_entry.row        = cursor_row;
    q_entry.glyph      = ch;
    if (cfg.enable) begin
      priority if (s_axis_tuser == REQ_CLEAR) begin
        cursor_column_next = '0;
        cursor_row_next    = '0;
        emit               = 1'b1;
        q_entry.two        = 1'b1;
        q_entry.cmd0       = CMD_CLEAR;
        q_entry.cmd1       = CMD_PRESENT;
      end else if (ch == CH_NEWLINE) begin
        cursor_column_next = '0;
        cursor_row_next    = nl_row;
        emit               = 1'b1;
        q_entry.two        = nl_scroll;
        q_entry.cmd0       = nl_scroll ? CMD_SCROLL : CMD_PRESENT;
        q_entry.cmd1       = CMD_PRESENT;
      end else if (ch == CH_CR) begin
        cursor_column_next = '0;
      end else if (ch == CH_TAB) begin
        if (tab_col >= eff_cols) begin
          cursor_column_next = '0;
          cursor_row_next    = nl_row;
          emit               = nl_scroll;
          q_entry.cmd0       = CMD_SCROLL;
        end else begin
          cursor_column_next = tab_col[CURC_W-1:0];
        end
      end else if (ch == CH_BACKSPACE) begin
        if (cursor_column != '0) begin
          cursor_column_next = dec_col;
          emit               = 1'b1;
          q_entry.cmd0       = CMD_DRAW;
          q_entry.col        = dec_col[CELLC_W-1:0];
          q_entry.glyph      = CH_SPACE;
        end
      end else if (ch >= CH_SPACE && ch <= CH_PRINT_MAX) begin
        emit         = 1'b1;
        q_entry.cmd0 = CMD_DRAW;
        q_entry.cmd1 = CMD_SCROLL;
        if (inc_col >= eff_cols) begin
          cursor_column_next = '0;
          cursor_row_next    = nl_row;
          q_entry.two        = nl_scroll;
        end else begin
          cursor_column_next = inc_col[CURC_W-1:0];
        end
      end else begin
        // other codes: no effect
      end
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
    end else if (accept) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tccc_back.sv -----
// Back end: expands queued jobs into result items in an output register.
// Depends on tccc_pkg; drains tccc_queue.
`default_nettype none
module tccc_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tccc_pkg::cfg_t                  cfg,
  input  wire logic                            q_not_empty,
  input  wire tccc_pkg::entry_t                q_entry,
  output logic                                 q_pop,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [7:0] cell_column, [14:8] cell_row, [22:15] glyph, [54:23] fore_color,
  // [86:55] back_color, [87] zero
  output logic [tccc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [1:0]                           m_axis_tuser,  // [1:0] command
  output logic                                 m_axis_tlast
);
  import tccc_pkg::*;

  logic    valid;
  logic    second;
  entry_t  ent;
  cmd_t    cmd;
  logic    fire;
  logic    done;

  logic [CELLC_W-1:0] o_col;
  logic [CELLR_W-1:0] o_row;
  logic [CHAR_W-1:0]  o_glyph;
  logic [COLOR_W-1:0] o_fg;
  logic [COLOR_W-1:0] o_bg;

  assign cmd   = second ? ent.cmd1 : ent.cmd0;
  assign fire  = valid && m_axis_tready;
  assign done  = second || !ent.two;
  assign q_pop = q_not_empty && (!valid || (fire && done));

  // Zero the fields a command does not use
  always_comb begin
    o_col   = '0;
    o_row   = '0;
    o_glyph = '0;
    o_fg    = '0;
    o_bg    = '0;
    unique case (cmd)
      CMD_DRAW: begin
        o_col   = ent.col;
        o_row   = ent.row;
        o_glyph = ent.glyph;
        o_fg    = cfg.fg_color;
        o_bg    = cfg.bg_color;
      end
      CMD_CLEAR: begin
        o_bg = cfg.bg_color;
      end
      CMD_SCROLL, CMD_PRESENT: begin
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tuser  = cmd;
  assign m_axis_tlast  = done;
  assign m_axis_tdata  = {1'b0, o_bg, o_fg, o_glyph, o_row, o_col};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      second <= 1'b0;
    end else if (q_pop) begin
      valid  <= 1'b1;
      second <= 1'b0;
    end else if (fire) begin
      if (done) begin
        valid  <= 1'b0;
        second <= 1'b0;
      end else begin
        second <= 1'b1;
      end
    end
  end

  a_second_only_pairs: assert property (@(posedge clk) disable iff (rst)
    second |-> (valid && ent.two))
    else $error("second command without a paired job");

  a_pair_continues: assert property (@(posedge clk) disable iff (rst)
    (fire && !done) |=> (valid && second))
    else $error("second command of a pair was dropped");

  a_second_not_draw: assert property (@(posedge clk) disable iff (rst)
    (valid && second) |-> (cmd != CMD_DRAW))
    else $error("draw issued as a trailing command");

endmodule
`default_nettype wire

// ----- rtl/text_console_cursor_controller.sv -----
// Top level of the text console cursor controller: registers, front, queue, back.
// Depends on tccc_pkg, tccc_front, tccc_queue and tccc_back.
//
//   port group  | dir | payload                                   | accepted when
//   ------------+-----+-------------------------------------------+-----------------------
//   s_axis_*    | in  | tuser: req_type; tdata: char_code         | tvalid && tready
//   m_axis_*    | out | tuser: command; tdata: cell fields,colors | tvalid && tready
//               |     | tlast: last command of the item           |
//   cfg_*       | in  | cfg_index selects register, cfg_data      | cfg_we
//
// The front takes one item per cycle while the two-entry queue has room and
// updates the cursor in that same cycle; items that produce no command leave
// nothing in the queue. The back puts out one command per cycle from its
// output register while m_axis_tready is high; an item that produces commands
// yields one or two of them on the single result channel.
// Reset is synchronous: cursor to column 0 row 0, registers to defaults,
// queue and output register empty. A stalled output fills the queue and
// then holds s_axis_tready low; the input side never blocks the output.
`default_nettype none
module text_console_cursor_controller (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [tccc_pkg::CHAR_W-1:0]       s_axis_tdata,  // [7:0] char_code
  input  wire logic                              s_axis_tuser,  // [0] req_type
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [7:0] cell_column, [14:8] cell_row, [22:15] glyph, [54:23] fore_color,
  // [86:55] back_color, [87] zero
  output logic [tccc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic [1:0]                             m_axis_tuser,  // [1:0] command
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [tccc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tccc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tccc_pkg::*;

  cfg_t    cfg;
  logic    q_full;
  logic    q_push;
  entry_t  q_wr;
  logic    q_pop;
  entry_t  q_rd;
  logic    q_not_empty;

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns   <= COLUMNS_RST;
      cfg.text_rows <= TEXT_ROWS_RST;
      cfg.enable    <= 1'b0;
      cfg.fg_color  <= FG_COLOR_RST;
      cfg.bg_color  <= BG_COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS:   cfg.columns   <= cfg_data[COLS_W-1:0];
        REG_TEXT_ROWS: cfg.text_rows <= cfg_data[ROWS_W-1:0];
        REG_ENABLE:    cfg.enable    <= cfg_data[0];
        REG_FG_COLOR:  cfg.fg_color  <= cfg_data[COLOR_W-1:0];
        REG_BG_COLOR:  cfg.bg_color  <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classify items and advance the cursor
  tccc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_wr)
  );

  // Hold jobs so each side can stall on its own
  tccc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (q_wr),
    .full      (q_full),
    .pop       (q_pop),
    .rd_data   (q_rd),
    .not_empty (q_not_empty)
  );

  // Expand jobs into one or two result items
  tccc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_not_empty   (q_not_empty),
    .q_entry       (q_rd),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ----- tb/text_console_cursor_controller_checker.sv -----
// Checker for the text console cursor controller: predicts the display commands
// from each accepted character item and compares them with the m_axis stream.
// Depends on tccc_pkg for the command type, register indexes and character codes.
`timescale 1ns / 100ps
module text_console_cursor_controller_checker
  import tccc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_code
  input  logic                  s_axis_tuser,   // [0] req_type
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] cell_column, [14:8] cell_row, [22:15] glyph, [54:23] fore_color,
  // [86:55] back_color, [87] zero
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,   // [1:0] command
  input  logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    cmd_t               cmd;
    logic [CELLC_W-1:0] col;
    logic [CELLR_W-1:0] row;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic               last;
  } console_cmd_t;

  console_cmd_t expected_cmds[$];

  // Shadow registers and cursor
  logic [COLS_W-1:0]  cols_reg;
  logic [ROWS_W-1:0]  rows_reg;
  logic               enable_reg;
  logic [COLOR_W-1:0] fg_reg;
  logic [COLOR_W-1:0] bg_reg;
  logic [CURC_W-1:0]  cur_col;
  logic [CURR_W-1:0]  cur_row;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic string show_cmd(console_cmd_t c);
    return $sformatf("cmd=%0d col=%0d row=%0d glyph=%0d fg=%h bg=%h last=%0d",
                     c.cmd, c.col, c.row, c.glyph, c.fg, c.bg, c.last);
  endfunction

  task automatic flag_failure(input string msg);
    if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic push_cmd(input cmd_t cmd, input logic [CELLC_W-1:0] col,
                          input logic [CELLR_W-1:0] row, input logic [CHAR_W-1:0] glyph,
                          input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    console_cmd_t c;
    c.cmd   = cmd;
    c.col   = col;
    c.row   = row;
    c.glyph = glyph;
    c.fg    = fg;
    c.bg    = bg;
    c.last  = 1'b0;
    expected_cmds.push_back(c);
  endtask

  // Column to 0, row down one; hold the bottom row and scroll past it
  task automatic line_feed();
    int rows_eff;
    int next_row;
    rows_eff = (rows_reg == 0) ? 1 : int'(rows_reg);
    if (rows_eff > ROW_CAP) rows_eff = ROW_CAP;
    cur_col  = '0;
    next_row = int'(cur_row) + 1;
    if (next_row >= rows_eff) begin
      next_row = rows_eff - 1;
      push_cmd(CMD_SCROLL, '0, '0, '0, '0, '0);
    end
    cur_row = next_row[CURR_W-1:0];
  endtask

  task automatic predict_commands(input logic req, input logic [CHAR_W-1:0] code);
    int first;
    int cols_eff;
    int stop;
    int nxt;
    console_cmd_t tail;
    if (!enable_reg) return;
    first    = expected_cmds.size();
    cols_eff = (cols_reg == 0) ? 1 : int'(cols_reg);
    if (cols_eff > COL_CAP) cols_eff = COL_CAP;
    if (req == REQ_CLEAR) begin
      push_cmd(CMD_CLEAR, '0, '0, '0, '0, bg_reg);
      push_cmd(CMD_PRESENT, '0, '0, '0, '0, '0);
      cur_col = '0;
      cur_row = '0;
    end else if (code == CH_NEWLINE) begin
      line_feed();
      push_cmd(CMD_PRESENT, '0, '0, '0, '0, '0);
    end else if (code == CH_CR) begin
      cur_col = '0;
    end else if (code == CH_TAB) begin
      stop = (int'(cur_col) / TAB_STOP + 1) * TAB_STOP;
      if (stop >= cols_eff) line_feed();
      else cur_col = stop[CURC_W-1:0];
    end else if (code == CH_BACKSPACE) begin
      if (cur_col != 0) begin
        cur_col = cur_col - 1'b1;
        push_cmd(CMD_DRAW, cur_col[CELLC_W-1:0], cur_row, CH_SPACE, fg_reg, bg_reg);
      end
    end else if (code >= CH_SPACE && code <= CH_PRINT_MAX) begin
      push_cmd(CMD_DRAW, cur_col[CELLC_W-1:0], cur_row, code, fg_reg, bg_reg);
      nxt = int'(cur_col) + 1;
      if (nxt >= cols_eff) line_feed();
      else cur_col = nxt[CURC_W-1:0];
    end
    if (expected_cmds.size() > first) begin
      tail      = expected_cmds[expected_cmds.size()-1];
      tail.last = 1'b1;
      expected_cmds[expected_cmds.size()-1] = tail;
    end
  endtask

  always @(posedge clk) begin
    console_cmd_t want;
    console_cmd_t got;
    if (rst) begin
      cols_reg   = COLUMNS_RST;
      rows_reg   = TEXT_ROWS_RST;
      enable_reg = 1'b0;
      fg_reg     = FG_COLOR_RST;
      bg_reg     = BG_COLOR_RST;
      cur_col    = '0;
      cur_row    = '0;
      expected_cmds.delete();
    end else begin
      // Results first: anything leaving now belongs to an earlier item
      if (m_axis_tvalid && m_axis_tready) begin
        got.cmd   = cmd_t'(m_axis_tuser);
        got.col   = m_axis_tdata[7:0];
        got.row   = m_axis_tdata[14:8];
        got.glyph = m_axis_tdata[22:15];
        got.fg    = m_axis_tdata[54:23];
        got.bg    = m_axis_tdata[86:55];
        got.last  = m_axis_tlast;
        if (expected_cmds.size() == 0) begin
          flag_failure({"unexpected command ", show_cmd(got)});
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want || m_axis_tdata[OUT_DATA_W-1] !== 1'b0)
            flag_failure($sformatf("expected %s, actual %s pad=%b", show_cmd(want),
                                   show_cmd(got), m_axis_tdata[OUT_DATA_W-1]));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMNS:   cols_reg   = cfg_data[COLS_W-1:0];
          REG_TEXT_ROWS: rows_reg   = cfg_data[ROWS_W-1:0];
          REG_ENABLE:    enable_reg = cfg_data[0];
          REG_FG_COLOR:  fg_reg     = cfg_data[COLOR_W-1:0];
          REG_BG_COLOR:  bg_reg     = cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_commands(s_axis_tuser, s_axis_tdata);
    end
    outstanding = expected_cmds.size();
  end

endmodule

// ----- tb/text_console_cursor_controller_tb.sv -----
// Top of the cursor controller testbench: clock, reset, stimulus and verdict.
// Depends on tccc_pkg, the controller RTL and text_console_cursor_controller_checker.
`timescale 1ns / 100ps
module text_console_cursor_controller_tb;
  import tccc_pkg::*;

  // Well above the slowest correct run: ~1900 items at up to two commands each,
  // both sides idling about a third of the time, plus register phases
  localparam int RUN_LIMIT = 400000;
  // Cycles to let the block finish internally once nothing is pending
  localparam int SETTLE_CYCLES = 8;

  // Character mixes for the random part
  typedef enum int {
    MIX_GENERAL,
    MIX_LONG_LINES,
    MIX_LINE_FEEDS
  } char_mix_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [CHAR_W-1:0]     s_axis_tdata = '0;   // [7:0] char_code
  logic                  s_axis_tuser = 1'b0; // [0] req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [7:0] cell_column, [14:8] cell_row, [22:15] glyph, [54:23] fore_color,
  // [86:55] back_color, [87] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;        // [1:0] command
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int cmds_pending;
  int cycle_count = 0;
  bit idling = 1'b1;   // clear to run both sides without gaps

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  text_console_cursor_controller u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  text_console_cursor_controller_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (fail_count),
    .outstanding   (cmds_pending)
  );

  // Display side: stall about 30 percent of the time unless idling is off
  always @(negedge clk) begin
    m_axis_tready <= idling ? ($urandom_range(99) >= 30) : 1'b1;
  end

  // Watchdog: a hung handshake or a missing command ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it. Enter and leave on a
  // falling edge; tvalid gets one assignment per time step, so back-to-back
  // items keep it high without a glitch.
  task automatic send_request(input logic req, input logic [CHAR_W-1:0] code);
    while (idling && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= code;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop tvalid and wait for every predicted command, then let the block settle
  // further in case a command-free item is still in flight
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cmds_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_console(input int cols, input int rows, input bit en,
                                 input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    write_reg(REG_COLUMNS, CFG_DATA_W'(cols));
    write_reg(REG_TEXT_ROWS, CFG_DATA_W'(rows));
    write_reg(REG_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BG_COLOR, bg);
  endtask

  // Pick one random item; the mix shifts weight toward long lines or toward
  // line feeds so the column wrap and the bottom-row scroll are both reached
  task automatic send_random(input char_mix_t mix);
    int roll;
    int p_lim, n_lim, t_lim, b_lim, c_lim, k_lim;
    roll = $urandom_range(99);
    case (mix)
      MIX_LONG_LINES: begin
        p_lim = 88; n_lim = 88; t_lim = 92; b_lim = 95; c_lim = 97; k_lim = 97;
      end
      MIX_LINE_FEEDS: begin
        p_lim = 25; n_lim = 80; t_lim = 88; b_lim = 93; c_lim = 95; k_lim = 96;
      end
      default: begin
        p_lim = 50; n_lim = 60; t_lim = 68; b_lim = 76; c_lim = 80; k_lim = 84;
      end
    endcase
    if (roll < p_lim)
      send_request(REQ_CHAR, CHAR_W'($urandom_range(CH_PRINT_MAX, CH_SPACE)));
    else if (roll < n_lim) send_request(REQ_CHAR, CH_NEWLINE);
    else if (roll < t_lim) send_request(REQ_CHAR, CH_TAB);
    else if (roll < b_lim) send_request(REQ_CHAR, CH_BACKSPACE);
    else if (roll < c_lim) send_request(REQ_CHAR, CH_CR);
    else if (roll < k_lim) send_request(REQ_CLEAR, CHAR_W'($urandom_range(255)));
    // any byte, a few of them as clear requests
    else send_request(($urandom_range(9) == 0) ? REQ_CLEAR : REQ_CHAR,
                      CHAR_W'($urandom_range(255)));
  endtask

  initial begin
    int ph;
    int k;
    int n_items;
    int cols;
    int rows;
    bit en;
    char_mix_t mix;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Console still disabled after reset: these must produce nothing
    send_request(REQ_CHAR, "A");
    send_request(REQ_CLEAR, 8'h00);
    send_request(REQ_CHAR, CH_NEWLINE);
    drain();

    // Directed: 16 columns, 3 rows
    program_console(16, 3, 1'b1, $urandom, $urandom);
    send_request(REQ_CHAR, CH_SPACE);       // lowest printable
    send_request(REQ_CHAR, CH_PRINT_MAX);   // highest printable
    send_request(REQ_CHAR, "A");
    send_request(REQ_CHAR, 8'd31);          // control codes just outside the
    send_request(REQ_CHAR, 8'd127);         // printable range do nothing
    send_request(REQ_CHAR, 8'd255);
    send_request(REQ_CHAR, 8'd0);
    send_request(REQ_CHAR, CH_BACKSPACE);   // erase the last glyph
    send_request(REQ_CHAR, CH_CR);
    send_request(REQ_CHAR, CH_BACKSPACE);   // at column 0: no effect
    send_request(REQ_CHAR, CH_TAB);         // to column 8
    send_request(REQ_CHAR, CH_TAB);         // past the last column: wrap to next row
    send_request(REQ_CHAR, CH_NEWLINE);     // to the bottom row
    send_request(REQ_CHAR, CH_NEWLINE);     // bottom row held: scroll, present
    send_request(REQ_CLEAR, 8'hFF);         // clear, present, home
    for (k = 0; k < 8; k++) send_request(REQ_CHAR, 8'h61 + k[7:0]);
    drain();

    // Register phases: extremes first, then shrink to small screens while the
    // cursor is still far out, then random small settings
    for (ph = 0; ph < 14; ph++) begin
      fg      = $urandom;
      bg      = $urandom;
      en      = 1'b1;
      mix     = MIX_GENERAL;
      n_items = 120;
      case (ph)
        0: begin cols = 0;   rows = 0;   fg = '0; bg = '1; n_items = 100; end
        1: begin cols = 1;   rows = 1;   fg = '1; bg = '0; n_items = 100; end
        2: begin cols = 511; rows = 255; mix = MIX_LONG_LINES; n_items = 300; end
        3: begin cols = 256; rows = 128; mix = MIX_LINE_FEEDS; n_items = 300; end
        4: begin cols = 300; rows = 200; n_items = 100; end
        5: begin cols = 7;   rows = 5;   en = 1'b0; n_items = 30; end
        default: begin
          cols = $urandom_range(24, 1);
          rows = $urandom_range(8, 1);
        end
      endcase
      program_console(cols, rows, en, fg, bg);
      // one phase with no gaps on either side
      idling = (ph != 7);
      for (k = 0; k < n_items; k++) begin
        // hold off mid-phase until the display side has caught up
        if (ph == 9 && k == 60) drain();
        send_random(mix);
      end
      drain();
    end
    idling = 1'b1;

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- text_console_cursor_controller.f -----
rtl/tccc_pkg.sv
rtl/tccc_queue.sv
rtl/tccc_front.sv
rtl/tccc_back.sv
rtl/text_console_cursor_controller.sv
tb/text_console_cursor_controller_checker.sv
tb/text_console_cursor_controller_tb.sv
